@@ hdl/sscc_pkg.sv @@
package sscc_pkg;

  localparam int unsigned INDEX_W = 32;
  localparam int unsigned COORD_W = 16;

  // Largest ring that is served; anything beyond it is flagged as a range error.
  localparam int unsigned RING_MAX = 32767;

  // Integer square root: sixteen digit steps, two per register stage.
  localparam int unsigned ROOT_STEPS = INDEX_W / 2;
  localparam int unsigned ROOT_STEPS_PER_STAGE = 2;
  localparam int unsigned ROOT_STAGES = ROOT_STEPS / ROOT_STEPS_PER_STAGE;

  localparam logic OP_INDEX_TO_COORD = 1'b0;
  localparam logic OP_COORD_TO_INDEX = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [INDEX_W-1:0]        n;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } req_t;

  // Partial root and remainder of the digit-by-digit square root.
  typedef struct packed {
    logic [15:0] q;
    logic [16:0] rem;
  } root_acc_t;

  typedef struct packed {
    req_t      req;
    root_acc_t acc;
  } root_t;

  typedef struct packed {
    logic                      op;
    logic                      err;
    logic [INDEX_W-1:0]        n;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [15:0]               k;
    logic [33:0]               tt;
  } ring_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [INDEX_W-1:0]        idx;
    logic                      err;
  } result_t;

  // One restoring step of the square root, consuming the next two bits of the radicand.
  function automatic root_acc_t root_step(root_acc_t a, logic [1:0] pair);
    logic [18:0] cur;
    logic [18:0] trial;
    root_acc_t   r;
    cur   = {a.rem, pair};
    trial = {1'b0, a.q, 2'b01};
    if (cur >= trial) begin
      r.rem = 17'(cur - trial);
      r.q   = {a.q[14:0], 1'b1};
    end else begin
      r.rem = cur[16:0];
      r.q   = {a.q[14:0], 1'b0};
    end
    return r;
  endfunction

  // Two radicand bits used by digit step it, most significant pair first.
  function automatic logic [1:0] root_pair(logic [INDEX_W-1:0] n, int unsigned it);
    logic [1:0] p;
    p = n[INDEX_W - 1 - 2 * it -: 2];
    return p;
  endfunction

endpackage

@@ hdl/sscc_isqrt.sv @@
module sscc_isqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sscc_pkg::req_t  in_req,
  output logic            out_valid,
  input  logic            out_ready,
  output sscc_pkg::root_t out_root
);
  import sscc_pkg::*;

  logic [ROOT_STAGES-1:0] vld;
  logic [ROOT_STAGES-1:0] rdy;
  root_t                  stage [ROOT_STAGES];

  genvar s;
  generate
    for (s = 0; s < ROOT_STAGES; s++) begin : g_stage
      root_t src;
      root_t stage_next;
      logic  src_valid;
      logic  dn_ready;

      if (s == 0) begin : g_first
        assign src       = '{req: in_req, acc: '0};
        assign src_valid = in_valid;
      end else begin : g_mid
        assign src       = stage[s-1];
        assign src_valid = vld[s-1];
      end

      if (s == ROOT_STAGES - 1) begin : g_last
        assign dn_ready = out_ready;
      end else begin : g_inner
        assign dn_ready = rdy[s+1];
      end

      always_comb begin
        stage_next = src;
        for (int unsigned j = 0; j < ROOT_STEPS_PER_STAGE; j++) begin
          stage_next.acc = root_step(stage_next.acc,
                                     root_pair(src.req.n, s * ROOT_STEPS_PER_STAGE + j));
        end
      end

      assign rdy[s] = !vld[s] || dn_ready;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else if (rdy[s]) begin
          vld[s] <= src_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && src_valid) begin
          stage[s] <= stage_next;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = vld[ROOT_STAGES-1];
  assign out_root  = stage[ROOT_STAGES-1];

endmodule

@@ hdl/sscc_ring.sv @@
module sscc_ring (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sscc_pkg::root_t in_root,
  output logic            out_valid,
  input  logic            out_ready,
  output sscc_pkg::ring_t out_ring
);
  import sscc_pkg::*;

  // First stage: ring number and range check. Second stage: corner square (2k+1)^2.
  logic        v1;
  logic        v2;
  logic        rdy1;
  logic        rdy2;
  ring_t       s1;
  ring_t       s2;
  ring_t       s1_next;
  ring_t       s2_next;
  logic [16:0] r;
  logic [15:0] ax;
  logic [15:0] ay;
  logic [15:0] k_coord;
  logic [16:0] t;
  logic [33:0] tt_mul;

  always_comb begin
    // The ceiling root made odd is 2k+1, so k is that value halved.
    r       = {1'b0, in_root.acc.q} + 17'(in_root.acc.rem != '0);
    ax      = in_root.req.x[15] ? 16'(~in_root.req.x + 16'sd1) : 16'(in_root.req.x);
    ay      = in_root.req.y[15] ? 16'(~in_root.req.y + 16'sd1) : 16'(in_root.req.y);
    k_coord = (ax > ay) ? ax : ay;

    s1_next    = '0;
    s1_next.op = in_root.req.op;
    s1_next.n  = in_root.req.n;
    s1_next.x  = in_root.req.x;
    s1_next.y  = in_root.req.y;
    s1_next.k  = (in_root.req.op == OP_COORD_TO_INDEX) ? k_coord : r[16:1];
    s1_next.err = (32'(s1_next.k) > RING_MAX) ||
                  ((in_root.req.op == OP_INDEX_TO_COORD) && (in_root.req.n == '0));
  end

  assign t      = {s1.k, 1'b1};
  assign tt_mul = t * t;

  always_comb begin
    s2_next    = s1;
    s2_next.tt = tt_mul;
  end

  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1 <= s1_next;
    end
    if (rdy2 && v1) begin
      s2 <= s2_next;
    end
  end

  assign in_ready  = rdy1;
  assign out_valid = v2;
  assign out_ring  = s2;

endmodule

@@ hdl/sscc_place.sv @@
module sscc_place (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sscc_pkg::ring_t   in_ring,
  output logic              out_valid,
  input  logic              out_ready,
  output sscc_pkg::result_t out_res
);
  import sscc_pkg::*;

  typedef struct packed {
    logic        op;
    logic        err;
    logic [15:0] k;
    logic [18:0] dof;
    logic [33:0] tt;
  } place_t;

  logic               v1;
  logic               v2;
  logic               rdy1;
  logic               rdy2;
  place_t             p1;
  place_t             p1_next;
  result_t            res;
  result_t            res_next;
  logic signed [19:0] ks;
  logic signed [19:0] xs;
  logic signed [19:0] ys;
  logic signed [19:0] off;
  logic [18:0]        d;
  logic signed [19:0] ks2;
  logic signed [19:0] ds2;
  logic signed [19:0] ss2;
  logic signed [19:0] xo;
  logic signed [19:0] yo;
  logic [18:0]        side1;
  logic [18:0]        side2;
  logic [18:0]        side3;

  // First stage: distance back from the corner for an index, or the offset
  // below the corner for a coordinate.
  always_comb begin
    ks = signed'({4'b0, in_ring.k});
    xs = 20'(in_ring.x);
    ys = 20'(in_ring.y);
    d  = 19'(in_ring.tt - 34'(in_ring.n));
    if (ys == -ks) begin
      off = ks - xs;
    end else if (xs == -ks) begin
      off = (ks <<< 1) + ks + ys;
    end else if (ys == ks) begin
      off = (ks <<< 2) + ks + xs;
    end else begin
      off = (ks <<< 3) - ks - ys;
    end
    p1_next.op  = in_ring.op;
    p1_next.err = in_ring.err;
    p1_next.k   = in_ring.k;
    p1_next.tt  = in_ring.tt;
    p1_next.dof = (in_ring.op == OP_COORD_TO_INDEX) ? off[18:0] : d;
  end

  // Second stage: pick the side of the ring and form the result.
  always_comb begin
    side1 = {2'b0, p1.k, 1'b0};
    side2 = {1'b0, p1.k, 2'b0};
    side3 = side1 + side2;
    ks2   = signed'({4'b0, p1.k});
    ds2   = signed'({1'b0, p1.dof});
    ss2   = signed'({1'b0, side1});
    if (p1.dof < side1) begin
      xo = ks2 - ds2;
      yo = -ks2;
    end else if (p1.dof < side2) begin
      xo = -ks2;
      yo = -ks2 + (ds2 - ss2);
    end else if (p1.dof < side3) begin
      xo = -ks2 + (ds2 - (ss2 <<< 1));
      yo = ks2;
    end else begin
      xo = ks2;
      yo = ks2 - (ds2 - (ss2 <<< 1) - ss2);
    end

    res_next = '0;
    res_next.err = p1.err;
    if (!p1.err) begin
      if (p1.op == OP_COORD_TO_INDEX) begin
        res_next.idx = 32'(p1.tt - 34'(p1.dof));
      end else begin
        res_next.x = xo[15:0];
        res_next.y = yo[15:0];
      end
    end
  end

  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p1 <= p1_next;
    end
    if (rdy2 && v1) begin
      res <= res_next;
    end
  end

  assign in_ready  = rdy1;
  assign out_valid = v2;
  assign out_res   = res;

endmodule

@@ hdl/square_spiral_index_coord_convert_top.sv @@
// Pipeline: 8 root stages, 2 ring stages and 2 placement stages lie between an accepted request
// and its result; throughput: one request per cycle, sustained while the output side is ready.
// The rate is set by the fully pipelined square root, two digit steps per stage.
// Reset (rst, synchronous, active high) clears every stage valid bit; data registers
// keep whatever they held and no result is presented until a new request passes through.
module square_spiral_index_coord_convert_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // index_in [31:0], x_in [47:32], y_in [63:48]
  input  logic        s_tuser,   // operation [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // x_out [15:0], y_out [31:16], index_out [63:32]
  output logic        m_tuser    // range_error [0]
);
  import sscc_pkg::*;

  // Request fields unpacked from the stream word.
  req_t    req;
  root_t   root;
  ring_t   ring;
  result_t res;
  logic    root_valid;
  logic    root_ready;
  logic    ring_valid;
  logic    ring_ready;

  assign req.op = s_tuser;
  assign req.n  = s_tdata[31:0];
  assign req.x  = s_tdata[47:32];
  assign req.y  = s_tdata[63:48];

  // Every stage holds its own valid bit and stalls only when the stage after it is
  // full and stalled, so bubbles close up and a waiting result does not block entry.

  // Integer square root of the cell number and its remainder, digit by digit.
  sscc_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (req),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_root  (root)
  );

  // Ring number for either direction, range check, and the ring's corner square.
  sscc_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (root_valid),
    .in_ready  (root_ready),
    .in_root   (root),
    .out_valid (ring_valid),
    .out_ready (ring_ready),
    .out_ring  (ring)
  );

  // Side selection and final coordinate or cell number; its last stage is the
  // output register.
  sscc_place u_place (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ring_valid),
    .in_ready  (ring_ready),
    .in_ring   (ring),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {res.idx, res.y, res.x};
  assign m_tuser = res.err;

  // With the sink ready, every stage can advance, so a request is always taken.
  a_ready_chain: assert property (@(posedge clk) m_tready |-> s_tready)
    else $error("input stalled while the output side is ready");

  // A flagged result carries no coordinate and no cell number.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 64'd0))
    else $error("range error result with nonzero data");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result presented right after reset");

endmodule

@@ dv/square_spiral_index_coord_convert_top_tb.sv @@
`timescale 1ns / 1ps

// Checks the square-spiral converter in both directions, cell number to
// coordinate and coordinate to cell number. A short table of requests goes
// first. Its corner and error rows carry results typed in by hand, and every
// other request is checked against a predictor written here. Random requests
// follow in three phases with different idle rates on each side, and one long
// stall on the result side that backs the pipe up.
module square_spiral_index_coord_convert_top_tb;
  import sscc_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 542;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned DRAIN_CYCLES    = 30;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_PROBES      = 25;

  // One row of the directed table. When pinned is set, the result is the one
  // typed into the row. Otherwise the predictor supplies it.
  typedef struct packed {
    req_t    req;
    bit      pinned;
    result_t res;
  } probe_row_t;

  typedef struct packed {
    bit      pinned;
    result_t res;
  } pin_t;

  // Rows hold: request {op, index, x, y}, pinned flag, result {x, y, index, error}.
  localparam probe_row_t PROBES [NUM_PROBES] = '{
    '{'{OP_INDEX_TO_COORD, 32'd1,          16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 32'd0, 1'b0}},
    '{'{OP_INDEX_TO_COORD, 32'd0,          16'h1234, 16'h5678}, 1'b1,
      '{16'h0000, 16'h0000, 32'd0, 1'b1}},
    '{'{OP_INDEX_TO_COORD, 32'd2,          16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_INDEX_TO_COORD, 32'd9,          16'h0000, 16'h0000}, 1'b1,
      '{16'h0001, 16'hFFFF, 32'd0, 1'b0}},
    '{'{OP_INDEX_TO_COORD, 32'd10,         16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_INDEX_TO_COORD, 32'd25,         16'h0000, 16'h0000}, 1'b1,
      '{16'h0002, 16'hFFFE, 32'd0, 1'b0}},
    '{'{OP_INDEX_TO_COORD, 32'd4294836225, 16'h0000, 16'h0000}, 1'b1,
      '{16'h7FFF, 16'h8001, 32'd0, 1'b0}},
    '{'{OP_INDEX_TO_COORD, 32'd4294836226, 16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 32'd0, 1'b1}},
    '{'{OP_INDEX_TO_COORD, 32'hFFFF_FFFF,  16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'h0000, 16'h0000, 32'd0, 1'b1}},
    '{'{OP_INDEX_TO_COORD, 32'd4294836224, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_INDEX_TO_COORD, 32'd4294574090, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_INDEX_TO_COORD, 32'h8000_0000,  16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 32'd1, 1'b0}},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'h0001, 16'hFFFF}, 1'b1,
      '{16'h0000, 16'h0000, 32'd9, 1'b0}},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'h7FFF, 16'h8001}, 1'b1,
      '{16'h0000, 16'h0000, 32'd4294836225, 1'b0}},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'h8000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 32'd0, 1'b1}},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'h0000, 16'h8000}, 1'b1,
      '{16'h0000, 16'h0000, 32'd0, 1'b1}},
    '{'{OP_COORD_TO_INDEX, 32'hFFFF_FFFF,  16'h8000, 16'h8000}, 1'b1,
      '{16'h0000, 16'h0000, 32'd0, 1'b1}},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'h7FFF, 16'h7FFF}, 1'b0, '0},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'h8001, 16'h8001}, 1'b0, '0},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'h8001, 16'h7FFF}, 1'b0, '0},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'h0001, 16'h0000}, 1'b0, '0},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'hFFFF, 16'h0000}, 1'b0, '0},
    '{'{OP_COORD_TO_INDEX, 32'd0,          16'h0000, 16'h0001}, 1'b0, '0},
    '{'{OP_COORD_TO_INDEX, 32'hFFFF_FFFF,  16'h7FFF, 16'h0000}, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // index_in [31:0], x_in [47:32], y_in [63:48]
  logic        s_tuser;   // operation [0]
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // x_out [15:0], y_out [31:16], index_out [63:32]
  logic        m_tuser;   // range_error [0]

  // Percent of cycles in which the request side and the result side idle.
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  // The request side asks for the long result stall and the result side
  // reports when it is over.
  bit          hold_go;
  bit          hold_done;

  int unsigned     mismatch_count = 0;
  longint unsigned cycle_count = 0;

  // The request side queues one pin per request before offering it. The
  // monitor turns the pin into an expected result when the request is taken.
  pin_t    pin_q[$];
  result_t coord_index_expect_q[$];

  square_spiral_index_coord_convert_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result of one request. Ring k of a cell number is the smallest k with
  // (2k+1)^2 >= index, found by binary search. Ring k ends at its corner
  // (k,-k), and the walk back from that corner runs along the bottom row, the
  // left column, the top row and then the right column.
  function automatic result_t spiral_convert(req_t r);
    result_t o;
    longint  nn, lo, hi, mid, k, side, t, d, x, y, ax, ay, m, v;
    o = '0;
    if (r.op == OP_INDEX_TO_COORD) begin
      nn = {32'd0, r.n};
      if (nn == 0) begin
        o.err = 1'b1;
      end else begin
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if ((2 * mid + 1) * (2 * mid + 1) >= nn) hi = mid;
          else lo = mid + 1;
        end
        k = lo;
        if (k > RING_MAX) begin
          o.err = 1'b1;
        end else begin
          side = 2 * k;
          t    = 2 * k + 1;
          d    = t * t - nn;
          if (d < side) begin
            x = k - d;
            y = -k;
          end else if (d < 2 * side) begin
            x = -k;
            y = -k + (d - side);
          end else if (d < 3 * side) begin
            x = -k + (d - 2 * side);
            y = k;
          end else begin
            x = k;
            y = k - (d - 3 * side);
          end
          o.x = x[15:0];
          o.y = y[15:0];
        end
      end
    end else begin
      x  = r.x;
      y  = r.y;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      k  = (ax > ay) ? ax : ay;
      if (k > RING_MAX) begin
        o.err = 1'b1;
      end else if (k == 0) begin
        o.idx = 32'd1;
      end else begin
        m = (2 * k + 1) * (2 * k + 1);
        if (y == -k) v = m - (k - x);
        else if (x == -k) v = m - 2 * k - (y + k);
        else if (y == k) v = m - 4 * k - (x + k);
        else v = m - 6 * k - (k - y);
        o.idx = v[31:0];
      end
    end
    return o;
  endfunction

  function automatic logic [15:0] extreme_coord();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'h7FFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random requests lean toward ring corners, ring boundaries, the top of the
  // index range and points placed exactly on a ring side. The field that the
  // operation ignores always carries random bits.
  function automatic req_t random_request();
    req_t   r;
    longint t, w;
    int     k, p;
    r.n = $urandom;
    r.x = 16'($urandom);
    r.y = 16'($urandom);
    case ($urandom_range(9))
      0, 1: begin
        r.op = OP_INDEX_TO_COORD;
      end
      2: begin
        r.op = OP_INDEX_TO_COORD;
        r.n  = $urandom_range(1, 2000);
      end
      3: begin
        r.op = OP_INDEX_TO_COORD;
        k    = $urandom_range(1) ? $urandom_range(0, 50) : $urandom_range(0, 32767);
        t    = 2 * k + 1;
        w    = t * t + $urandom_range(0, 2) - 1;
        r.n  = w[31:0];
      end
      4: begin
        r.op = OP_INDEX_TO_COORD;
        r.n  = 32'hFFFF_FFFF - $urandom_range(0, 300000);
      end
      5, 6: begin
        r.op = OP_COORD_TO_INDEX;
      end
      7: begin
        r.op = OP_COORD_TO_INDEX;
        r.x  = 16'(int'($urandom_range(0, 40)) - 20);
        r.y  = 16'(int'($urandom_range(0, 40)) - 20);
      end
      8: begin
        r.op = OP_COORD_TO_INDEX;
        k    = $urandom_range(1) ? $urandom_range(1, 40) : $urandom_range(1, 32767);
        p    = int'($urandom_range(0, 2 * k)) - k;
        case ($urandom_range(3))
          0: begin r.x = 16'(p);  r.y = 16'(-k); end
          1: begin r.x = 16'(-k); r.y = 16'(p);  end
          2: begin r.x = 16'(p);  r.y = 16'(k);  end
          default: begin r.x = 16'(k); r.y = 16'(p); end
        endcase
      end
      default: begin
        r.op = OP_COORD_TO_INDEX;
        r.x  = extreme_coord();
        r.y  = extreme_coord();
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("cycle %0d: %s mismatch, expected %0h, got %0h", cycle_count, what, want, got);
    mismatch_count++;
  endtask

  // Offers one request and returns at the edge where it is taken. Valid is
  // only lowered when the request side idles, so back-to-back requests keep
  // it high.
  task automatic offer_request(input req_t r, input bit pinned, input result_t res);
    pin_t pin;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    pin.pinned = pinned;
    pin.res    = res;
    pin_q      = {pin_q, pin};
    s_tvalid <= 1'b1;
    s_tdata  <= {r.y, r.x, r.n};
    s_tuser  <= r.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Request side: reset, the directed table, then three random phases.
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    src_idle_pct = 19;
    snk_idle_pct = 50;
    hold_go      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_PROBES; i++) begin
      offer_request(PROBES[i].req, PROBES[i].pinned, PROBES[i].res);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 19; snk_idle_pct = 50; end
        1: begin src_idle_pct = 50; snk_idle_pct = 19; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // With both sides at full rate, a long stall on the result side fills
        // the pipe while requests keep coming.
        if (phase == 2 && i == 100) hold_go = 1'b1;
        offer_request(random_request(), 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (coord_index_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: random backpressure, plus one long stall counted here.
  initial begin
    int unsigned held;
    m_tready  = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        for (held = 0; held < LONG_HOLD; held++) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Monitor: turns each taken request into an expected result and compares
  // each taken result, field by field, with the oldest expectation.
  req_t    taken_req;
  pin_t    taken_pin;
  result_t taken_res;
  result_t want_res;
  result_t got_res;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        taken_req.op = s_tuser;
        taken_req.n  = s_tdata[31:0];
        taken_req.x  = s_tdata[47:32];
        taken_req.y  = s_tdata[63:48];
        taken_pin    = pin_q.pop_front();
        taken_res    = taken_pin.pinned ? taken_pin.res : spiral_convert(taken_req);
        coord_index_expect_q = {coord_index_expect_q, taken_res};
      end
      if (m_tvalid && m_tready) begin
        got_res.x   = m_tdata[15:0];
        got_res.y   = m_tdata[31:16];
        got_res.idx = m_tdata[63:32];
        got_res.err = m_tuser;
        if (coord_index_expect_q.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, got_res.idx);
        end else begin
          want_res = coord_index_expect_q.pop_front();
          if (got_res.x !== want_res.x)
            report_mismatch("x_out", {16'd0, want_res.x}, {16'd0, got_res.x});
          if (got_res.y !== want_res.y)
            report_mismatch("y_out", {16'd0, want_res.y}, {16'd0, got_res.y});
          if (got_res.idx !== want_res.idx)
            report_mismatch("index_out", want_res.idx, got_res.idx);
          if (got_res.err !== want_res.err)
            report_mismatch("range_error", {31'd0, want_res.err}, {31'd0, got_res.err});
        end
      end
    end
  end

  // A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
